/* rtl/core/piw_pkg.sv */
// ============================================================================
// piw_pkg - shared types and constants for the point-in-polygon winding unit
// Defaults, opcode values, quadrant map, step classes and the control and
// status structs passed between the top level and the vertex datapath.
// ============================================================================
package piw_pkg;

    // Parameter defaults
    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_BITS_DEF   = 32;

    // Fixed field widths
    localparam int VCOUNT_BITS = 9;
    localparam int INDEX_BITS  = 8;

    // A polygon needs at least this many vertices
    localparam int MIN_VERTICES = 3;

    // Opcodes of the operation field
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // Quadrant of a vertex relative to the point, indexed [dy<0][dx<0]
    localparam logic [1:0] QUAD_MAP [2][2] = '{'{2'd0, 2'd1}, '{2'd3, 2'd2}};

    // Quadrant changes that move the winding count
    localparam logic signed [2:0] DELTA_NEG3 = -3'sd3;
    localparam logic signed [2:0] DELTA_NEG2 = -3'sd2;
    localparam logic signed [2:0] DELTA_POS2 = 3'sd2;
    localparam logic signed [2:0] DELTA_POS3 = 3'sd3;

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_INC,
        STEP_DEC,
        STEP_INC_GE,
        STEP_DEC_LT
    } piw_step_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } piw_state_t;

    // Top level to datapath: clear of the count, read data tags
    typedef struct packed {
        logic clear;
        logic vld;
        logic first;
    } piw_walk_ctrl_t;

    // Datapath to top level
    typedef struct packed {
        logic busy;
        logic wind_nz;
    } piw_walk_stat_t;

    function automatic logic [1:0] piw_quadrant(input logic dy_neg, input logic dx_neg);
        return QUAD_MAP[dy_neg][dx_neg];
    endfunction

    // Classify the quadrant change from the previous vertex to this one
    function automatic piw_step_t piw_step_of(input logic [1:0] q, input logic [1:0] pq);
        logic signed [2:0] delta;
        piw_step_t         step;
        delta = $signed({1'b0, q}) - $signed({1'b0, pq});
        case (delta)
            DELTA_NEG3: step = STEP_INC;
            DELTA_POS3: step = STEP_DEC;
            DELTA_NEG2: step = STEP_INC_GE;
            DELTA_POS2: step = STEP_DEC_LT;
            default:    step = STEP_NONE;
        endcase
        return step;
    endfunction

endpackage

/* rtl/core/point_in_polygon_winding_unit.sv */
// ============================================================================
// point_in_polygon_winding_unit - quadrant winding-number point test
// Vertices are loaded into a RAM; a test point walks all vertices in use and
// reports inside/outside plus an any-inside flag accumulated over a group.
// ============================================================================
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | operation, vertex_index, coord_x, coord_y,
//          |                      | group_last
//  out     | out_valid / out_stall| point_inside, group_any_inside, group_end
//  cfg     | cfg_valid / cfg_ready| vertex_count
//
//  A load transfer writes the vertex RAM and leaves the unit idle. A test with
//  n vertices in use makes one vertex RAM read per cycle over n + 1 reads (the
//  last vertex first, then all in order), then the datapath drains.
//  Fewer than three vertices gives an outside result without a vertex read.
//  A finished result waits in the output register; the next test can run
//  while it waits and only holds at its end if the register is still full.
//  Reset clears control state and the group flag; the vertex RAM is not reset.
//
module point_in_polygon_winding_unit #(
    parameter int MAX_VERTICES = piw_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = piw_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [piw_pkg::INDEX_BITS-1:0]      vertex_index,
    input  logic signed [COORD_BITS-1:0]        coord_x,
    input  logic signed [COORD_BITS-1:0]        coord_y,
    input  logic                                group_last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                point_inside,
    output logic                                group_any_inside,
    output logic                                group_end,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [piw_pkg::VCOUNT_BITS-1:0]     vertex_count
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    piw_pkg::piw_state_t            state_reg, state_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [CW-1:0]                  n_reg, n_next;
    logic [CW-1:0]                  n_clamp;
    logic [piw_pkg::VCOUNT_BITS-1:0] vcount_reg;
    logic signed [COORD_BITS-1:0]   px_reg;
    logic signed [COORD_BITS-1:0]   py_reg;
    logic                           last_reg;
    logic                           rd_vld_reg;
    logic                           rd_first_reg;
    logic                           group_hit_reg, group_hit_next;
    logic                           out_valid_reg;
    logic                           inside_reg;
    logic                           any_reg;
    logic                           end_reg;

    logic                           rd_issue;
    logic                           rd_first;
    logic                           test_acc;
    logic                           load_acc;
    logic                           finish;
    logic                           out_free;
    logic                           idx_ok;
    logic                           hit;
    logic [AW-1:0]                  rd_addr;

    piw_pkg::piw_walk_ctrl_t        walk_ctrl;
    piw_pkg::piw_walk_stat_t        walk_stat;
    logic [2*COORD_BITS-1:0]        rd_data;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            vcount_reg <= vertex_count;
        end
    end

    // Vertices in use, limited to the store depth
    always_comb
    begin
        if (32'(vcount_reg) > 32'(MAX_VERTICES))
        begin
            n_clamp = CW'(MAX_VERTICES);
        end
        else
        begin
            n_clamp = CW'(vcount_reg);
        end
    end

    assign idx_ok   = 32'(vertex_index) < 32'(MAX_VERTICES);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = state_reg != piw_pkg::ST_IDLE;

    // Sequencer: next state and controls
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        rd_issue   = 1'b0;
        rd_first   = 1'b0;
        test_acc   = 1'b0;
        load_acc   = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            piw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == piw_pkg::OP_TEST)
                    begin
                        test_acc = 1'b1;
                        n_next   = n_clamp;
                        cnt_next = '0;
                        if (32'(n_clamp) < 32'(piw_pkg::MIN_VERTICES))
                        begin
                            state_next = piw_pkg::ST_DRAIN;
                        end
                        else
                        begin
                            state_next = piw_pkg::ST_WALK;
                        end
                    end
                    else
                    begin
                        load_acc = 1'b1;
                    end
                end
            end
            piw_pkg::ST_WALK:
            begin
                rd_issue = 1'b1;
                rd_first = cnt_reg == '0;
                if (cnt_reg == n_reg)
                begin
                    state_next = piw_pkg::ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            piw_pkg::ST_DRAIN:
            begin
                if (!walk_stat.busy && out_free)
                begin
                    finish     = 1'b1;
                    state_next = piw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = piw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= piw_pkg::ST_IDLE;
            cnt_reg      <= '0;
            n_reg        <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            n_reg        <= n_next;
            rd_vld_reg   <= rd_issue;
            rd_first_reg <= rd_first;
        end
    end

    // Test point and group mark of the running test
    always_ff @(posedge clk)
    begin
        if (test_acc)
        begin
            px_reg   <= coord_x;
            py_reg   <= coord_y;
            last_reg <= group_last;
        end
    end

    // Last vertex first as predecessor, then vertices in order
    always_comb
    begin
        if (rd_first)
        begin
            rd_addr = AW'(n_reg - CW'(1));
        end
        else
        begin
            rd_addr = AW'(cnt_reg - CW'(1));
        end
    end

    piw_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (load_acc && idx_ok),
        .waddr (AW'(vertex_index)),
        .wdata ({coord_y, coord_x}),
        .re    (rd_issue),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign walk_ctrl.clear = test_acc;
    assign walk_ctrl.vld   = rd_vld_reg;
    assign walk_ctrl.first = rd_first_reg;

    piw_walk #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (walk_ctrl),
        .rd_data (rd_data),
        .px      (px_reg),
        .py      (py_reg),
        .stat    (walk_stat)
    );

    // Group flag: accumulate hits, clear after the group's last point
    always_comb
    begin
        hit            = group_hit_reg | walk_stat.wind_nz;
        group_hit_next = group_hit_reg;
        if (finish)
        begin
            group_hit_next = last_reg ? 1'b0 : hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_hit_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            group_hit_reg <= group_hit_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            inside_reg <= walk_stat.wind_nz;
            any_reg    <= hit;
            end_reg    <= last_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign point_inside     = inside_reg;
    assign group_any_inside = any_reg;
    assign group_end        = end_reg;

endmodule

/* rtl/core/piw_ram.sv */
// ============================================================================
// piw_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module piw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/piw_walk.sv */
// ============================================================================
// piw_walk - vertex datapath of the winding test
// Takes vertex read data, forms point-relative offsets, classifies the
// quadrant change, forms both cross products and steps the winding count.
// ============================================================================
module piw_walk #(
    parameter int MAX_VERTICES = piw_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = piw_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  piw_pkg::piw_walk_ctrl_t        ctrl,
    input  logic [2*COORD_BITS-1:0]        rd_data,
    input  logic signed [COORD_BITS-1:0]   px,
    input  logic signed [COORD_BITS-1:0]   py,
    output piw_pkg::piw_walk_stat_t        stat
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int WW = $clog2(MAX_VERTICES + 1) + 1;

    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;

    // Stage 1: offsets of the vertex from the point
    logic signed [DW-1:0] dx1_reg, dx1_next;
    logic signed [DW-1:0] dy1_reg, dy1_next;
    logic                 vld1_reg;
    logic                 first1_reg;

    // Stage 2: previous vertex, cross products, step class
    logic [1:0]           q;
    logic signed [DW-1:0] pdx_reg;
    logic signed [DW-1:0] pdy_reg;
    logic [1:0]           pq_reg;
    logic signed [PW-1:0] prod_a_reg, prod_a_next;
    logic signed [PW-1:0] prod_b_reg, prod_b_next;
    piw_pkg::piw_step_t   step_reg, step_next;
    logic                 vld2_reg;

    // Stage 3: winding count
    logic                 cross_ge;
    logic signed [WW-1:0] wind_reg, wind_next;

    assign vx = rd_data[COORD_BITS-1:0];
    assign vy = rd_data[2*COORD_BITS-1:COORD_BITS];

    // Exact offsets at one extra bit
    always_comb
    begin
        dx1_next = {vx[COORD_BITS-1], vx} - {px[COORD_BITS-1], px};
        dy1_next = {vy[COORD_BITS-1], vy} - {py[COORD_BITS-1], py};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.vld)
        begin
            dx1_reg    <= dx1_next;
            dy1_reg    <= dy1_next;
            first1_reg <= ctrl.first;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= ctrl.vld;
            vld2_reg <= vld1_reg & ~first1_reg;
        end
    end

    // Quadrant, step class and both cross products
    always_comb
    begin
        q           = piw_pkg::piw_quadrant(dy1_reg[DW-1], dx1_reg[DW-1]);
        step_next   = piw_pkg::piw_step_of(q, pq_reg);
        prod_a_next = PW'(pdx_reg) * PW'(dy1_reg);
        prod_b_next = PW'(pdy_reg) * PW'(dx1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (vld1_reg)
        begin
            pdx_reg    <= dx1_reg;
            pdy_reg    <= dy1_reg;
            pq_reg     <= q;
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            step_reg   <= step_next;
        end
    end

    // Winding update; a diagonal jump is decided by the product compare
    always_comb
    begin
        cross_ge  = prod_a_reg >= prod_b_reg;
        wind_next = wind_reg;
        if (vld2_reg)
        begin
            case (step_reg)
                piw_pkg::STEP_INC:    wind_next = wind_reg + WW'(1);
                piw_pkg::STEP_DEC:    wind_next = wind_reg - WW'(1);
                piw_pkg::STEP_INC_GE:
                begin
                    if (cross_ge)
                    begin
                        wind_next = wind_reg + WW'(1);
                    end
                end
                piw_pkg::STEP_DEC_LT:
                begin
                    if (!cross_ge)
                    begin
                        wind_next = wind_reg - WW'(1);
                    end
                end
                default:              wind_next = wind_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wind_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            wind_reg <= '0;
        end
        else
        begin
            wind_reg <= wind_next;
        end
    end

    assign stat.busy    = ctrl.vld | vld1_reg | vld2_reg;
    assign stat.wind_nz = wind_reg != '0;

endmodule

/* tb/tb_point_in_polygon_winding_unit.sv */
// ============================================================================
// tb_point_in_polygon_winding_unit - self-checking bench for the winding unit
// Loads polygons into the vertex store, sets the vertex count and fires test
// points at the unit. Each point's winding verdict and group flag are
// predicted on acceptance and checked, field by field, against each output
// transfer. Both sides idle and stall at random, and one long receiver
// hold-off fills the unit until it stalls its input.
// ============================================================================
`timescale 1ns / 100ps

module tb_point_in_polygon_winding_unit;

    localparam int NV = piw_pkg::MAX_VERTICES_DEF;
    localparam int CW = piw_pkg::COORD_BITS_DEF;

    // A test walks up to NV + 1 vertices and drains a short pipe
    localparam int LATENCY_CYCLES = NV + 20;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RX_HOLD_CYCLES = 400;

    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

    // Coordinate spreads used when drawing polygons and points
    localparam int SPAN_FULL   = 0;
    localparam int SPAN_WIDE   = 1;
    localparam int SPAN_NARROW = 2;
    localparam int SPAN_TINY   = 3;

    typedef struct packed {
        logic point_in;
        logic group_hit;
        logic closes;
    } verdict_t;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic                              operation;
    logic [piw_pkg::INDEX_BITS-1:0]    vertex_index;
    logic signed [CW-1:0]              coord_x;
    logic signed [CW-1:0]              coord_y;
    logic                              group_last;
    logic                              out_valid;
    logic                              out_stall;
    logic                              point_inside;
    logic                              group_any_inside;
    logic                              group_end;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [piw_pkg::VCOUNT_BITS-1:0]   vertex_count;

    // Shadow of the unit: vertex store, count register and group flag
    logic signed [CW-1:0]              poly_x [NV];
    logic signed [CW-1:0]              poly_y [NV];
    int unsigned                       poly_count;
    bit                                group_seen;

    verdict_t                          verdict_q [$];
    verdict_t                          want;
    int                                mismatch_count;
    int                                cycle_count;
    bit                                tx_quiet;
    bit                                rx_quiet;
    bit                                rx_hold_request;

    point_in_polygon_winding_unit #(
        .MAX_VERTICES (NV),
        .COORD_BITS   (CW)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .vertex_index     (vertex_index),
        .coord_x          (coord_x),
        .coord_y          (coord_y),
        .group_last       (group_last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .point_inside     (point_inside),
        .group_any_inside (group_any_inside),
        .group_end        (group_end),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .vertex_count     (vertex_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_point_in_polygon_winding_unit: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Winding number of the stored polygon around (px, py), quadrant method
    function automatic bit winding_inside(input logic signed [CW-1:0] px,
                                          input logic signed [CW-1:0] py);
        int                   n;
        int                   i;
        int                   w;
        int                   dq;
        logic signed [CW:0]   pdx, pdy, cdx, cdy;
        logic signed [2*CW+1:0] lhs, rhs;
        logic [1:0]           pq, cq;
        n = (poly_count > NV) ? NV : poly_count;
        if (n < piw_pkg::MIN_VERTICES)
            return 1'b0;
        w   = 0;
        pdx = poly_x[n-1] - px;
        pdy = poly_y[n-1] - py;
        pq  = {pdy[CW], pdy[CW] ^ pdx[CW]};
        for (i = 0; i < n; i++)
        begin
            cdx = poly_x[i] - px;
            cdy = poly_y[i] - py;
            cq  = {cdy[CW], cdy[CW] ^ cdx[CW]};
            lhs = pdx * cdy;
            rhs = pdy * cdx;
            dq  = int'(cq) - int'(pq);
            case (dq)
                piw_pkg::DELTA_NEG3: w++;
                piw_pkg::DELTA_POS3: w--;
                piw_pkg::DELTA_NEG2:
                begin
                    if (lhs >= rhs)
                        w++;
                end
                piw_pkg::DELTA_POS2:
                begin
                    if (lhs < rhs)
                        w--;
                end
                default: ;
            endcase
            pdx = cdx;
            pdy = cdy;
            pq  = cq;
        end
        return w != 0;
    endfunction

    // Update the shadow for one accepted transfer; tests queue a verdict
    task automatic record_item(input logic op, input logic [piw_pkg::INDEX_BITS-1:0] idx,
                               input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                               input logic last);
        verdict_t v;
        if (op == piw_pkg::OP_LOAD)
        begin
            poly_x[idx] = x;
            poly_y[idx] = y;
        end
        else
        begin
            v.point_in  = winding_inside(x, y);
            group_seen  = group_seen | v.point_in;
            v.group_hit = group_seen;
            v.closes    = last;
            verdict_q.push_back(v);
            if (last)
                group_seen = 1'b0;
        end
    endtask

    // Offer one item after a random gap; returns at the accepting rising edge
    task automatic send_item(input logic op, input logic [piw_pkg::INDEX_BITS-1:0] idx,
                             input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic last);
        int gap;
        bit taken;
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        vertex_index <= idx;
        coord_x      <= x;
        coord_y      <= y;
        group_last   <= last;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !in_stall;
        end
        record_item(op, idx, x, y, last);
    endtask

    // Drop valid, wait for every verdict, then let any trailing walk finish
    task automatic settle();
        int waited;
        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (verdict_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (verdict_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d test results never arrived", verdict_q.size()));
            verdict_q.delete();
        end
        repeat (LATENCY_CYCLES) @(negedge clk);
    endtask

    // Register write; called at a falling edge with the unit idle
    task automatic write_vertex_count(input logic [piw_pkg::VCOUNT_BITS-1:0] value);
        cfg_valid    <= 1'b1;
        vertex_count <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        poly_count = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [CW-1:0] rand_coord(input int span);
        int r;
        if (span == SPAN_FULL)
        begin
            case ($urandom_range(0, 15))
                0:       return CMIN;
                1:       return CMAX;
                2:       return '0;
                default: return $urandom;
            endcase
        end
        r = (span == SPAN_WIDE) ? (1 << 20) : (span == SPAN_NARROW) ? 1000 : 8;
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // Load vertices 0 .. n-1 with random content
    task automatic load_polygon(input int n, input int span);
        int i;
        for (i = 0; i < n; i++)
            send_item(piw_pkg::OP_LOAD, piw_pkg::INDEX_BITS'(i), rand_coord(span),
                      rand_coord(span), 1'($urandom_range(0, 1)));
    endtask

    // Probe point: free, on a vertex, or on the midpoint of an edge
    task automatic pick_probe(input int n, input int span,
                              output logic signed [CW-1:0] px,
                              output logic signed [CW-1:0] py);
        int                 way;
        int                 a;
        int                 b;
        logic signed [CW:0] sx, sy;
        way = (n == 0) ? 0 : $urandom_range(0, 9);
        a   = (n == 0) ? 0 : $urandom_range(0, n - 1);
        b   = (n == 0) ? 0 : (a + 1) % n;
        if (way < 6)
        begin
            px = rand_coord(span);
            py = rand_coord(span);
        end
        else if (way < 8)
        begin
            px = poly_x[a];
            py = poly_y[a];
        end
        else
        begin
            sx = poly_x[a] + poly_x[b];
            sy = poly_y[a] + poly_y[b];
            px = sx[CW:1];
            py = sy[CW:1];
        end
    endtask

    task automatic send_test(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic last);
        send_item(piw_pkg::OP_TEST, piw_pkg::INDEX_BITS'($urandom_range(0, 255)), x, y, last);
    endtask

    // Fewer than three vertices: always outside, no store read
    task automatic test_short_polygons();
        write_vertex_count(9'd0);
        send_test(CMIN, CMAX, 1'b0);
        send_test(CMAX, CMIN, 1'b1);
        settle();
        write_vertex_count(9'd2);
        send_test('0, '0, 1'b1);
        settle();
        write_vertex_count(9'd1);
        send_test(CMAX, CMAX, 1'b0);
    endtask

    // Diamond spanning the whole coordinate range; top store entry written
    task automatic test_extreme_diamond();
        settle();
        write_vertex_count(9'd4);
        send_item(piw_pkg::OP_LOAD, 8'd0, '0, CMIN, 1'b1);
        send_item(piw_pkg::OP_LOAD, 8'd1, CMAX, '0, 1'b0);
        send_item(piw_pkg::OP_LOAD, 8'd2, '0, CMAX, 1'b0);
        send_item(piw_pkg::OP_LOAD, 8'd3, CMIN, '0, 1'b1);
        send_item(piw_pkg::OP_LOAD, 8'd255, CMAX, CMIN, 1'b0);
        send_test('0, '0, 1'b0);
        send_test(CMAX, CMAX, 1'b1);
        send_test(CMIN, CMIN, 1'b0);
        // lies exactly on the lower-left edge
        send_test(32'shC000_0000, 32'shC000_0000, 1'b1);
    endtask

    // Edge through the point across diagonal quadrants: cross products tie
    task automatic test_diagonal_ties();
        settle();
        write_vertex_count(9'd3);
        send_item(piw_pkg::OP_LOAD, 8'd0, -32'sd4, -32'sd4, 1'b0);
        send_item(piw_pkg::OP_LOAD, 8'd1, 32'sd4, 32'sd4, 1'b0);
        send_item(piw_pkg::OP_LOAD, 8'd2, -32'sd4, 32'sd4, 1'b0);
        send_test('0, '0, 1'b0);
        send_test(32'sd1, '0, 1'b0);
        send_test('0, 32'sd1, 1'b1);
    endtask

    // Random polygons of small size with random probes and stray loads
    task automatic test_random_polygons();
        int                   phase;
        int                   k;
        int                   n;
        int                   span;
        logic signed [CW-1:0] px, py;
        for (phase = 0; phase < 12; phase++)
        begin
            settle();
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            n    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
            span = $urandom_range(SPAN_FULL, SPAN_TINY);
            write_vertex_count(piw_pkg::VCOUNT_BITS'(n));
            load_polygon(n, span);
            for (k = 0; k < 28; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(piw_pkg::OP_LOAD, piw_pkg::INDEX_BITS'($urandom_range(0, 255)),
                              rand_coord(span), rand_coord(span),
                              1'($urandom_range(0, 1)));
                else
                begin
                    pick_probe(n, span, px, py);
                    send_test(px, py, $urandom_range(0, 3) == 0);
                end
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // Full store, then counts beyond the store size which clamp to it
    task automatic test_large_polygon();
        int                   k;
        logic signed [CW-1:0] px, py;
        settle();
        write_vertex_count(piw_pkg::VCOUNT_BITS'(NV));
        load_polygon(NV, SPAN_WIDE);
        for (k = 0; k < 8; k++)
        begin
            pick_probe(NV, SPAN_WIDE, px, py);
            send_test(px, py, $urandom_range(0, 2) == 0);
        end
        settle();
        write_vertex_count(9'd511);
        for (k = 0; k < 4; k++)
        begin
            pick_probe(NV, SPAN_WIDE, px, py);
            send_test(px, py, k == 3);
        end
        settle();
        write_vertex_count(9'd300);
        for (k = 0; k < 3; k++)
        begin
            pick_probe(NV, SPAN_WIDE, px, py);
            send_test(px, py, 1'b1);
        end
    endtask

    // Receiver holds off while tests keep coming: the unit must stall its input
    task automatic test_output_backpressure();
        int                   k;
        logic signed [CW-1:0] px, py;
        settle();
        write_vertex_count(9'd4);
        load_polygon(4, SPAN_NARROW);
        tx_quiet        = 1'b1;
        rx_hold_request = 1'b1;
        for (k = 0; k < 14; k++)
        begin
            pick_probe(4, SPAN_NARROW, px, py);
            send_test(px, py, 1'($urandom_range(0, 1)));
        end
        tx_quiet = 1'b0;
    endtask

    // Receiver: random stall before each transfer, one long hold on request
    initial
    begin : receiver
        int w;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            w = rx_quiet ? 0 : $urandom_range(0, 12);
            if (rx_hold_request)
            begin
                w               = RX_HOLD_CYCLES;
                rx_hold_request = 1'b0;
            end
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
                report_mismatch("result transfer with no test outstanding");
            else
            begin
                want = verdict_q.pop_front();
                if (point_inside !== want.point_in)
                    report_mismatch($sformatf("point_inside %b, predicted %b",
                                              point_inside, want.point_in));
                if (group_any_inside !== want.group_hit)
                    report_mismatch($sformatf("group_any_inside %b, predicted %b",
                                              group_any_inside, want.group_hit));
                if (group_end !== want.closes)
                    report_mismatch($sformatf("group_end %b, predicted %b",
                                              group_end, want.closes));
            end
        end
    end

    // Sequence of tests
    initial
    begin : stimulus
        in_valid        = 1'b0;
        operation       = piw_pkg::OP_LOAD;
        vertex_index    = '0;
        coord_x         = '0;
        coord_y         = '0;
        group_last      = 1'b0;
        cfg_valid       = 1'b0;
        vertex_count    = '0;
        poly_count      = 0;
        group_seen      = 1'b0;
        mismatch_count  = 0;
        cycle_count     = 0;
        tx_quiet        = 1'b0;
        rx_quiet        = 1'b0;
        rx_hold_request = 1'b0;
        rst_n           = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_short_polygons();
        test_extreme_diamond();
        test_diagonal_ties();
        test_random_polygons();
        test_output_backpressure();
        test_large_polygon();
        settle();

        if (mismatch_count == 0)
            $display("tb_point_in_polygon_winding_unit: PASS");
        else
            $display("tb_point_in_polygon_winding_unit: FAIL");
        $finish;
    end

endmodule
